// ----- rtl/rra_pkg.sv -----
`timescale 1ns / 1ps

package rra_pkg;

	// Fixed field widths of the item and result ports.
	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 4;
	localparam int AMT_W    = 16;
	localparam int NEED_W   = 17;
	localparam int VAL_W    = 16;
	localparam int CFG_W    = 5;
	localparam int STATUS_W = 2;

	// APB register file: two 32-bit registers at byte addresses 0 and 4.
	localparam int CFG_AW = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_PROC_COUNT = 1'b0;
	localparam logic REG_RES_COUNT  = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LD_AVAIL = 3'd0,
		FUNC_LD_ALLOC = 3'd1,
		FUNC_LD_MAX   = 3'd2,
		FUNC_REQ      = 3'd3,
		FUNC_READ     = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		DEC_GRANT      = 2'd0,
		DEC_OVER_NEED  = 2'd1,
		DEC_OVER_AVAIL = 2'd2,
		DEC_BAD_PROC   = 2'd3
	} dec_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_OUT,
		ST_DEC_BEGIN,
		ST_CHECK,
		ST_CHECK_END,
		ST_JUDGE,
		ST_APPLY,
		ST_APPLY_END,
		ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_step;
		logic latch;
		logic ld_avail;
		logic ld_alloc;
		logic ld_max;
		logic req_store;
		logic rd_issue;
		logic walk_rst;
		logic chk_issue;
		logic app_issue;
		logic out_dec;
		logic out_rd;
		logic buf_clr;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_last;
		logic walk_last;
		logic bad_proc;
		logic check_fail;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/resource_request_admission.sv -----
// Loads are written in the accepting cycle; a read-back item passes the table read
// register, then the result register. The last request element starts a decision over
// the N effective resources: one table walk to check need and available, one to
// apply a grant. The walk length is set by the single read port of the allocation/claim
// memories. After reset all MAX_PROCESSES*MAX_RESOURCES entries (256 by default) are
// cleared with items stalled; configuration returns to 16/16 and is writable at once.
`timescale 1ns / 1ps

module resource_request_admission #(
	parameter int MAX_PROCESSES = 16,
	parameter int MAX_RESOURCES = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rra_pkg::FUNC_W-1:0]          func,
	input  logic [rra_pkg::IDX_W-1:0]           process_index,
	input  logic [rra_pkg::IDX_W-1:0]           resource_index,
	input  logic [rra_pkg::AMT_W-1:0]           amount,
	input  logic                                last_element,
	// Result output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                result_kind,
	output logic                                granted,
	output logic [rra_pkg::STATUS_W-1:0]        status,
	output logic signed [rra_pkg::NEED_W-1:0]   need_value,
	output logic [rra_pkg::VAL_W-1:0]           allocation_value,
	output logic [rra_pkg::VAL_W-1:0]           available_value,
	// APB configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rra_pkg::CFG_AW-1:0]          paddr,
	input  logic [rra_pkg::PDATA_W-1:0]         pwdata,
	output logic [rra_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);
	import rra_pkg::*;

	// The controller sequences each item: loads finish in the accepting cycle,
	// a read issues its table access on acceptance and fills the result register in
	// the following state, and the last request element runs the decision.
	// The datapath owns the tables, the request buffer, the walk counter and the
	// result register, so a finished result can wait there while the block goes
	// back to idle and takes the next item.
	cmd_t             cmd;
	sts_t             sts;
	logic [CFG_W-1:0] process_count;
	logic [CFG_W-1:0] resource_count;

	// Process and resource counts live in a small APB register file.
	rra_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.process_count  (process_count),
		.resource_count (resource_count)
	);

	// The state machine: table clear after reset, item dispatch, and the
	// check walk, judgment and apply walk of a decision.
	rra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.func         (func),
		.last_element (last_element),
		.sts          (sts),
		.cmd          (cmd),
		.in_stall     (in_stall)
	);

	// The check walk reads one table entry per cycle and folds the need and
	// available comparisons into two sticky flags; the apply walk reads the
	// allocation entry and writes it back raised by the request in the next cycle.
	rra_dpath #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.MAX_RESOURCES (MAX_RESOURCES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.process_index    (process_index),
		.resource_index   (resource_index),
		.amount           (amount),
		.process_count    (process_count),
		.resource_count   (resource_count),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.result_kind      (result_kind),
		.granted          (granted),
		.status           (status),
		.need_value       (need_value),
		.allocation_value (allocation_value),
		.available_value  (available_value)
	);

endmodule

// ----- rtl/rra_regs.sv -----
`timescale 1ns / 1ps

module rra_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rra_pkg::CFG_AW-1:0]  paddr,
	input  logic [rra_pkg::PDATA_W-1:0] pwdata,
	output logic [rra_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [rra_pkg::CFG_W-1:0]   process_count,
	output logic [rra_pkg::CFG_W-1:0]   resource_count
);
	import rra_pkg::*;

	logic [CFG_W-1:0] process_count_q;
	logic [CFG_W-1:0] resource_count_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[CFG_AW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= CFG_W'(16);
			resource_count_q <= CFG_W'(16);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_PROC_COUNT: process_count_q  <= pwdata[CFG_W-1:0];
				REG_RES_COUNT:  resource_count_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PROC_COUNT: prdata = PDATA_W'(process_count_q);
			REG_RES_COUNT:  prdata = PDATA_W'(resource_count_q);
			default:        prdata = '0;
		endcase
	end

	assign process_count  = process_count_q;
	assign resource_count = resource_count_q;

endmodule

// ----- rtl/rra_ctrl.sv -----
`timescale 1ns / 1ps

module rra_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [rra_pkg::FUNC_W-1:0] func,
	input  logic                       last_element,
	input  rra_pkg::sts_t              sts,
	output rra_pkg::cmd_t              cmd,
	output logic                       in_stall
);
	import rra_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_REQ:  if (last_element) state_nxt = ST_DEC_BEGIN;
						FUNC_READ: state_nxt = ST_RD_OUT;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_RD_OUT: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			ST_DEC_BEGIN: begin
				state_nxt = sts.bad_proc ? ST_DONE : ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.walk_last) state_nxt = ST_CHECK_END;
			end
			ST_CHECK_END: state_nxt = ST_JUDGE;
			ST_JUDGE: begin
				state_nxt = sts.check_fail ? ST_DONE : ST_APPLY;
			end
			ST_APPLY: begin
				if (sts.walk_last) state_nxt = ST_APPLY_END;
			end
			ST_APPLY_END: state_nxt = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					unique case (func)
						FUNC_LD_AVAIL: cmd.ld_avail  = 1'b1;
						FUNC_LD_ALLOC: cmd.ld_alloc  = 1'b1;
						FUNC_LD_MAX:   cmd.ld_max    = 1'b1;
						FUNC_REQ:      cmd.req_store = 1'b1;
						FUNC_READ:     cmd.rd_issue  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_RD_OUT: cmd.out_rd = sts.out_free;
			ST_DEC_BEGIN: cmd.walk_rst = 1'b1;
			ST_CHECK: cmd.chk_issue = 1'b1;
			ST_CHECK_END: ;
			ST_JUDGE: cmd.walk_rst = !sts.check_fail;
			ST_APPLY: cmd.app_issue = 1'b1;
			ST_APPLY_END: ;
			ST_DONE: begin
				cmd.out_dec = sts.out_free;
				cmd.buf_clr = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/rra_dpath.sv -----
`timescale 1ns / 1ps

module rra_dpath #(
	parameter int MAX_PROCESSES = 16,
	parameter int MAX_RESOURCES = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rra_pkg::cmd_t                       cmd,
	output rra_pkg::sts_t                       sts,
	input  logic [rra_pkg::IDX_W-1:0]           process_index,
	input  logic [rra_pkg::IDX_W-1:0]           resource_index,
	input  logic [rra_pkg::AMT_W-1:0]           amount,
	input  logic [rra_pkg::CFG_W-1:0]           process_count,
	input  logic [rra_pkg::CFG_W-1:0]           resource_count,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                result_kind,
	output logic                                granted,
	output logic [rra_pkg::STATUS_W-1:0]        status,
	output logic signed [rra_pkg::NEED_W-1:0]   need_value,
	output logic [rra_pkg::VAL_W-1:0]           allocation_value,
	output logic [rra_pkg::VAL_W-1:0]           available_value
);
	import rra_pkg::*;

	localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int PCW   = ($clog2(MAX_PROCESSES + 1) > CFG_W) ?
	                       $clog2(MAX_PROCESSES + 1) : CFG_W;
	localparam int RCW   = ($clog2(MAX_RESOURCES + 1) > CFG_W) ?
	                       $clog2(MAX_RESOURCES + 1) : CFG_W;
	localparam int CW    = COUNT_WIDTH;

	// Allocation and maximum-claim tables.
	logic [CW-1:0] alloc_mem [DEPTH];
	logic [CW-1:0] max_mem   [DEPTH];
	logic [CW-1:0] alloc_rd_q;
	logic [CW-1:0] max_rd_q;

	logic [CW-1:0] avail_q [MAX_RESOURCES];
	logic [CW-1:0] req_q   [MAX_RESOURCES];

	logic [AW-1:0]    clr_addr_q;
	logic [RIW-1:0]   walk_q;
	logic [RIW-1:0]   idx_s1;
	logic [AW-1:0]    addr_s1;
	logic             chk_s1;
	logic             app_s1;
	logic [IDX_W-1:0] p_q;
	logic [RIW-1:0]   r_q;
	logic             ent_ok_q;
	logic             need_fail_q;
	logic             avail_fail_q;
	logic             out_valid_q;

	logic             in_p_ok;
	logic             in_r_ok;
	logic             in_ent_ok;
	logic [AW-1:0]    in_addr;
	logic [RIW-1:0]   in_ridx;
	logic [CW-1:0]    in_amt;
	logic [AW-1:0]    walk_addr;
	logic [AW-1:0]    raddr;
	logic             rd_en;
	logic [PCW-1:0]   np;
	logic [RCW-1:0]   nr;
	logic [RIW-1:0]   aidx;
	logic [CW-1:0]    avail_rd;
	logic [CW-1:0]    req_rd;
	logic signed [CW:0]    need;
	logic signed [CW:0]    req_x;
	logic signed [CW+17:0] need_x;
	logic [CW+15:0]   alloc_x;
	logic [CW+15:0]   avail_x;
	logic             alloc_we;
	logic [AW-1:0]    alloc_waddr;
	logic [CW-1:0]    alloc_wdata;
	logic             max_we;
	logic [AW-1:0]    max_waddr;
	logic [CW-1:0]    max_wdata;
	dec_status_t      dec_status;

	// Effective counts: zero acts as one, large values saturate.
	always_comb begin
		if (process_count == '0) begin
			np = PCW'(1);
		end else if (int'(process_count) > MAX_PROCESSES) begin
			np = PCW'(MAX_PROCESSES);
		end else begin
			np = PCW'(process_count);
		end
		if (resource_count == '0) begin
			nr = RCW'(1);
		end else if (int'(resource_count) > MAX_RESOURCES) begin
			nr = RCW'(MAX_RESOURCES);
		end else begin
			nr = RCW'(resource_count);
		end
	end

	assign in_p_ok   = int'(process_index) < MAX_PROCESSES;
	assign in_r_ok   = int'(resource_index) < MAX_RESOURCES;
	assign in_ent_ok = in_p_ok & in_r_ok;
	assign in_addr   = in_ent_ok ?
	                   AW'(int'(process_index) * MAX_RESOURCES + int'(resource_index)) : '0;
	assign in_ridx   = in_r_ok ? RIW'(resource_index) : '0;
	assign in_amt    = CW'(amount);
	assign walk_addr = AW'(int'(p_q) * MAX_RESOURCES + int'(walk_q));

	assign rd_en = cmd.rd_issue | cmd.chk_issue | cmd.app_issue;
	assign raddr = cmd.rd_issue ? in_addr : walk_addr;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			alloc_rd_q <= alloc_mem[raddr];
			max_rd_q   <= max_mem[raddr];
		end
	end

	always_comb begin
		alloc_we    = 1'b0;
		alloc_waddr = clr_addr_q;
		alloc_wdata = '0;
		if (cmd.clr_step) begin
			alloc_we = 1'b1;
		end else if (cmd.ld_alloc && in_ent_ok) begin
			alloc_we    = 1'b1;
			alloc_waddr = in_addr;
			alloc_wdata = in_amt;
		end else if (app_s1) begin
			alloc_we    = 1'b1;
			alloc_waddr = addr_s1;
			alloc_wdata = alloc_rd_q + req_rd;
		end
		max_we    = 1'b0;
		max_waddr = clr_addr_q;
		max_wdata = '0;
		if (cmd.clr_step) begin
			max_we = 1'b1;
		end else if (cmd.ld_max && in_ent_ok) begin
			max_we    = 1'b1;
			max_waddr = in_addr;
			max_wdata = in_amt;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_we) alloc_mem[alloc_waddr] <= alloc_wdata;
		if (max_we)   max_mem[max_waddr]     <= max_wdata;
	end

	// One read address serves both the read-back and the walk.
	assign aidx     = cmd.out_rd ? r_q : idx_s1;
	assign avail_rd = avail_q[aidx];
	assign req_rd   = req_q[idx_s1];
	assign need     = $signed({1'b0, max_rd_q}) - $signed({1'b0, alloc_rd_q});
	assign req_x    = $signed({1'b0, req_rd});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				avail_q[i] <= '0;
				req_q[i]   <= '0;
			end
		end else begin
			if (cmd.ld_avail && in_r_ok) begin
				avail_q[in_ridx] <= in_amt;
			end else if (app_s1) begin
				avail_q[idx_s1] <= avail_rd - req_rd;
			end
			if (cmd.buf_clr) begin
				for (int i = 0; i < MAX_RESOURCES; i++) req_q[i] <= '0;
			end else if (cmd.req_store && in_r_ok) begin
				req_q[in_ridx] <= in_amt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			walk_q       <= '0;
			chk_s1       <= 1'b0;
			app_s1       <= 1'b0;
			need_fail_q  <= 1'b0;
			avail_fail_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.walk_rst) begin
				walk_q       <= '0;
				need_fail_q  <= 1'b0;
				avail_fail_q <= 1'b0;
			end else begin
				if (cmd.chk_issue || cmd.app_issue) walk_q <= walk_q + RIW'(1);
				if (chk_s1) begin
					if (req_x > need)     need_fail_q  <= 1'b1;
					if (req_rd > avail_rd) avail_fail_q <= 1'b1;
				end
			end
			chk_s1 <= cmd.chk_issue;
			app_s1 <= cmd.app_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= walk_q;
		addr_s1 <= walk_addr;
		if (cmd.latch) begin
			p_q      <= process_index;
			r_q      <= in_ridx;
			ent_ok_q <= in_ent_ok;
		end
	end

	always_comb begin
		if (PCW'(p_q) >= np) begin
			dec_status = DEC_BAD_PROC;
		end else if (need_fail_q) begin
			dec_status = DEC_OVER_NEED;
		end else if (avail_fail_q) begin
			dec_status = DEC_OVER_AVAIL;
		end else begin
			dec_status = DEC_GRANT;
		end
	end

	assign need_x  = (CW + 18)'(need);
	assign alloc_x = (CW + 16)'(alloc_rd_q);
	assign avail_x = (CW + 16)'(avail_rd);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_dec || cmd.out_rd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_dec) begin
			result_kind      <= 1'b0;
			granted          <= (dec_status == DEC_GRANT);
			status           <= dec_status;
			need_value       <= '0;
			allocation_value <= '0;
			available_value  <= '0;
		end else if (cmd.out_rd) begin
			result_kind <= 1'b1;
			granted     <= 1'b0;
			if (ent_ok_q) begin
				status           <= DEC_GRANT;
				need_value       <= need_x[NEED_W-1:0];
				allocation_value <= alloc_x[VAL_W-1:0];
				available_value  <= avail_x[VAL_W-1:0];
			end else begin
				status           <= DEC_BAD_PROC;
				need_value       <= '0;
				allocation_value <= '0;
				available_value  <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.clr_last   = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.walk_last  = (RCW'(walk_q) == nr - RCW'(1));
	assign sts.bad_proc   = (PCW'(p_q) >= np);
	assign sts.check_fail = need_fail_q | avail_fail_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

// ----- verif/resource_request_admission_tb.sv -----
`timescale 1ns / 1ps

module resource_request_admission_tb;
	import rra_pkg::*;

	localparam int MAX_PROC = 16;
	localparam int MAX_RES = 16;

	// Kind of a result item: a request decision or the read-back of one table entry.
	localparam logic KIND_DECISION = 1'b0;
	localparam logic KIND_READBACK = 1'b1;

	// A decision walks the resources at most twice; the drain wait is long enough
	// to be sure that nothing is still in flight.
	localparam int DRAIN_CYCLES = 60;
	// The receiver holds off this long once, so that the input side backs up.
	localparam int HOLD_CYCLES = 300;
	// Cycles in which nothing is accepted on either side before the run gives up.
	// The longest quiet stretch of a correct run is the table clear after reset
	// or the long hold plus one decision, far below this.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 70;
	localparam int PRESSURE_ITEMS = 24;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  proc;
		logic [IDX_W-1:0]  res_idx;
		logic [AMT_W-1:0]  amount;
		logic              last;
	} request_item_t;

	typedef struct packed {
		logic                     kind;
		logic                     granted;
		dec_status_t              status;
		logic signed [NEED_W-1:0] need;
		logic [VAL_W-1:0]         alloc;
		logic [VAL_W-1:0]         avail;
	} outcome_t;

	// Stall patterns of the result receiver.
	typedef enum int {
		SINK_FREE,
		SINK_RANDOM,
		SINK_TOGGLE,
		SINK_HEAVY
	} sink_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [FUNC_W-1:0]        func;
	logic [IDX_W-1:0]         process_index;
	logic [IDX_W-1:0]         resource_index;
	logic [AMT_W-1:0]         amount;
	logic                     last_element;
	logic                     out_valid;
	logic                     out_stall;
	logic                     result_kind;
	logic                     granted;
	logic [STATUS_W-1:0]      status;
	logic signed [NEED_W-1:0] need_value;
	logic [VAL_W-1:0]         allocation_value;
	logic [VAL_W-1:0]         available_value;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_AW-1:0]        paddr;
	logic [PDATA_W-1:0]       pwdata;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;

	// Shadow copy of the block's tables, request buffer and count registers.
	logic [VAL_W-1:0] alloc_tbl [MAX_PROC*MAX_RES];
	logic [VAL_W-1:0] claim_tbl [MAX_PROC*MAX_RES];
	logic [VAL_W-1:0] avail_vec [MAX_RES];
	logic [VAL_W-1:0] req_buf [MAX_RES];
	logic [CFG_W-1:0] proc_cnt;
	logic [CFG_W-1:0] res_cnt;

	// Results predicted for accepted items, oldest first.
	outcome_t pending_results[$];

	int  item_count = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  burst_left = 0;
	bit  pace_on = 1'b1;
	bit  hold_req = 1'b0;

	resource_request_admission u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.process_index    (process_index),
		.resource_index   (resource_index),
		.amount           (amount),
		.last_element     (last_element),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.granted          (granted),
		.status           (status),
		.need_value       (need_value),
		.allocation_value (allocation_value),
		.available_value  (available_value),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A count register of zero behaves as one, and anything above the table size
	// behaves as the table size.
	function automatic int eff_count(logic [CFG_W-1:0] v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : int'(v);
	endfunction

	// Need is maximum claim minus allocation and goes negative when a process holds
	// more than it claimed.
	function automatic int need_at(int p, int r);
		return int'(claim_tbl[p*MAX_RES + r]) - int'(alloc_tbl[p*MAX_RES + r]);
	endfunction

	function automatic request_item_t mk(int f, int p, int r, int a, int l);
		request_item_t it;
		it.func = f[FUNC_W-1:0];
		it.proc = p[IDX_W-1:0];
		it.res_idx = r[IDX_W-1:0];
		it.amount = a[AMT_W-1:0];
		it.last = l[0];
		return it;
	endfunction

	// Applies one accepted item to the shadow state. Returns 1 and fills res when
	// the item produces a result.
	function automatic bit admit_item(input request_item_t it, output outcome_t res);
		int np;
		int nr;
		int r;
		int n;
		dec_status_t verdict;
		res = '0;
		case (it.func)
			FUNC_LD_AVAIL: avail_vec[it.res_idx] = it.amount;
			FUNC_LD_ALLOC: alloc_tbl[{it.proc, it.res_idx}] = it.amount;
			FUNC_LD_MAX: claim_tbl[{it.proc, it.res_idx}] = it.amount;
			FUNC_REQ: begin
				req_buf[it.res_idx] = it.amount;
				if (!it.last)
					return 1'b0;
				np = eff_count(proc_cnt, MAX_PROC);
				nr = eff_count(res_cnt, MAX_RES);
				verdict = DEC_GRANT;
				if (it.proc >= np)
					verdict = DEC_BAD_PROC;
				// Need is checked over all resources in use before available is.
				for (r = 0; r < nr && verdict == DEC_GRANT; r++)
					if (int'(req_buf[r]) > need_at(it.proc, r))
						verdict = DEC_OVER_NEED;
				for (r = 0; r < nr && verdict == DEC_GRANT; r++)
					if (req_buf[r] > avail_vec[r])
						verdict = DEC_OVER_AVAIL;
				if (verdict == DEC_GRANT) begin
					for (r = 0; r < nr; r++) begin
						alloc_tbl[it.proc*MAX_RES + r] = alloc_tbl[it.proc*MAX_RES + r] + req_buf[r];
						avail_vec[r] = avail_vec[r] - req_buf[r];
					end
				end
				// Every decision leaves an empty request buffer behind.
				foreach (req_buf[i])
					req_buf[i] = '0;
				res.kind = KIND_DECISION;
				res.granted = (verdict == DEC_GRANT);
				res.status = verdict;
				return 1'b1;
			end
			FUNC_READ: begin
				n = need_at(it.proc, it.res_idx);
				res.kind = KIND_READBACK;
				res.status = DEC_GRANT;
				res.need = n[NEED_W-1:0];
				res.alloc = alloc_tbl[{it.proc, it.res_idx}];
				res.avail = avail_vec[it.res_idx];
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [31:0] expv,
		input logic [31:0] actv);
		if (expv !== actv) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, expv, actv);
		end
	endtask

	// Sends one item. The sender works in bursts; at the start of each burst it
	// drops valid for a random gap unless pacing is off.
	task automatic offer_item(input request_item_t it);
		outcome_t res;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 10);
			if (pace_on) begin
				repeat (gap) begin
					@(negedge clk);
					in_valid = 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		func = it.func;
		process_index = it.proc;
		resource_index = it.res_idx;
		amount = it.amount;
		last_element = it.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (admit_item(it, res))
			pending_results.push_back(res);
		// Unused function codes are ignored by the block and do not count.
		if (it.func <= FUNC_READ)
			item_count++;
	endtask

	task automatic apb_transfer(input logic wr, input logic idx,
		input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Registers are only changed while the block is idle: every result in and
	// enough cycles after it for a decision that produced nothing visible yet.
	task automatic set_counts(input int p, input int r);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_transfer(1'b1, REG_PROC_COUNT, p, rd);
		proc_cnt = p[CFG_W-1:0];
		apb_transfer(1'b1, REG_RES_COUNT, r, rd);
		res_cnt = r[CFG_W-1:0];
		apb_transfer(1'b0, REG_PROC_COUNT, '0, rd);
		check_field("process_count", proc_cnt, rd[CFG_W-1:0]);
		apb_transfer(1'b0, REG_RES_COUNT, '0, rd);
		check_field("resource_count", res_cnt, rd[CFG_W-1:0]);
	endtask

	// Directed cases: count extremes, every function, each kind of decision,
	// negative need, buffer clearing, ignored codes and out-of-range registers.
	task automatic test_directed_cases();
		int f;
		offer_item(mk(FUNC_LD_AVAIL, 0, 0, 16'hFFFF, 1));
		offer_item(mk(FUNC_LD_AVAIL, 0, 15, 16'h0000, 0));
		offer_item(mk(FUNC_LD_MAX, 15, 15, 16'hFFFF, 0));
		offer_item(mk(FUNC_LD_ALLOC, 15, 15, 16'h0000, 1));
		// Largest positive need.
		offer_item(mk(FUNC_READ, 15, 15, 16'h0000, 0));
		offer_item(mk(FUNC_LD_ALLOC, 0, 0, 16'hFFFF, 0));
		offer_item(mk(FUNC_LD_MAX, 0, 0, 16'h0000, 1));
		// Most negative need.
		offer_item(mk(FUNC_READ, 0, 0, 16'hFFFF, 1));
		// Within need, but nothing of resource 15 is available.
		offer_item(mk(FUNC_REQ, 15, 15, 1, 1));
		// Process 0 holds more than it claims, so any request exceeds need.
		offer_item(mk(FUNC_REQ, 0, 0, 1, 1));
		// A two-element request that is granted, then seen through a read.
		offer_item(mk(FUNC_LD_MAX, 3, 0, 16'h8000, 0));
		offer_item(mk(FUNC_REQ, 3, 0, 16'h8000, 0));
		offer_item(mk(FUNC_REQ, 3, 15, 0, 1));
		offer_item(mk(FUNC_READ, 3, 0, 0, 0));
		// Need of process 3 on resource 0 is now zero; this is only granted if the
		// earlier element was cleared from the buffer.
		offer_item(mk(FUNC_REQ, 3, 1, 0, 1));
		for (f = FUNC_READ + 1; f < (1 << FUNC_W); f++)
			offer_item(mk(f, $urandom, $urandom, $urandom, $urandom));

		// Four processes and one resource: process 4 is out of range, and an
		// element on a resource outside the walk is neither checked nor applied.
		set_counts(4, 1);
		offer_item(mk(FUNC_REQ, 4, 0, 0, 1));
		offer_item(mk(FUNC_REQ, 3, 5, 16'hFFFF, 1));
		offer_item(mk(FUNC_READ, 3, 5, 0, 1));

		// A process count of zero acts as one; a resource count of 31 acts as 16.
		set_counts(0, 31);
		offer_item(mk(FUNC_REQ, 1, 2, 0, 1));
		offer_item(mk(FUNC_REQ, 0, 9, 0, 1));
		offer_item(mk(FUNC_READ, 0, 9, 16'h5A5A, 0));
	endtask

	// The receiver stops taking results for a long stretch while items keep
	// coming back to back, so the block fills and has to stall its input.
	task automatic test_backpressure();
		int i;
		hold_req = 1'b1;
		pace_on = 1'b0;
		for (i = 0; i < PRESSURE_ITEMS; i++)
			offer_item(mk((i % 3 == 0) ? FUNC_LD_AVAIL : FUNC_READ,
				$urandom, $urandom, $urandom, $urandom));
		pace_on = 1'b1;
	endtask

	// Random traffic over several register settings. Most of it is complete
	// requests from processes in range, with amounts mostly chosen to fit need
	// and availability so that grants are common; the rest refreshes the tables,
	// reads entries back, or is plain noise including abandoned request elements.
	task automatic test_random_traffic();
		int phase;
		int stop_at;
		int np;
		int nr;
		int pick;
		int n;
		int k;
		int p;
		int r;
		int f;
		int bound;
		int amt;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_counts(16, 16);
				1: set_counts(1, 1);
				2: set_counts(0, 31);
				3: set_counts(31, 0);
				4: set_counts($urandom_range(1, 16), $urandom_range(1, 16));
				default: set_counts($urandom_range(0, 31), $urandom_range(0, 31));
			endcase
			stop_at = item_count + PHASE_ITEMS;
			while (item_count < stop_at) begin
				np = eff_count(proc_cnt, MAX_PROC);
				nr = eff_count(res_cnt, MAX_RES);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					p = ($urandom_range(0, 9) != 0) ? $urandom_range(0, np - 1)
						: $urandom_range(0, MAX_PROC - 1);
					// Sometimes prime one entry so that the claim covers the allocation.
					if ($urandom_range(0, 1) == 1) begin
						r = $urandom_range(0, nr - 1);
						amt = $urandom_range(0, 16'hFFFF);
						offer_item(mk(FUNC_LD_MAX, p, r, amt, $urandom));
						offer_item(mk(FUNC_LD_ALLOC, p, r, $urandom_range(0, amt), $urandom));
						offer_item(mk(FUNC_LD_AVAIL, $urandom, r, $urandom, $urandom));
					end
					n = $urandom_range(1, (nr < 4) ? nr : 4);
					for (k = 0; k < n; k++) begin
						r = ($urandom_range(0, 7) != 0) ? $urandom_range(0, nr - 1)
							: $urandom_range(0, MAX_RES - 1);
						bound = need_at(p, r);
						if (int'(avail_vec[r]) < bound)
							bound = avail_vec[r];
						if (bound < 0)
							bound = 0;
						amt = ($urandom_range(0, 9) < 7) ? $urandom_range(0, bound) : $urandom;
						offer_item(mk(FUNC_REQ, p, r, amt, (k == n - 1)));
					end
				end else if (pick < 72) begin
					p = $urandom_range(0, np - 1);
					r = $urandom_range(0, nr - 1);
					f = $urandom_range(FUNC_LD_AVAIL, FUNC_LD_MAX);
					amt = $urandom;
					// Allocations mostly stay within the claim, keeping need positive.
					if (f == FUNC_LD_ALLOC && $urandom_range(0, 4) != 0)
						amt = $urandom_range(0, claim_tbl[p*MAX_RES + r]);
					offer_item(mk(f, p, r, amt, $urandom));
				end else if (pick < 88) begin
					offer_item(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom));
				end else begin
					offer_item(mk($urandom_range(0, (1 << FUNC_W) - 1),
						$urandom, $urandom, $urandom, $urandom));
				end
			end
		end
	endtask

	// Every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		outcome_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0h status %0h", result_kind, status);
			end else begin
				exp_r = pending_results.pop_front();
				check_field("result_kind", exp_r.kind, result_kind);
				check_field("granted", exp_r.granted, granted);
				check_field("status", exp_r.status, status);
				check_field("need_value", exp_r.need, need_value);
				check_field("allocation_value", exp_r.alloc, allocation_value);
				check_field("available_value", exp_r.avail, available_value);
			end
		end
	end

	// The receiver changes its stall pattern every so often, and honors one
	// long hold-off when the back-pressure test asks for it.
	initial begin : result_sink
		sink_mode_t mode;
		int mode_left;
		int hold_left;
		out_stall = 1'b0;
		mode = SINK_FREE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					SINK_FREE: out_stall = 1'b0;
					SINK_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
					SINK_TOGGLE: out_stall = ~out_stall;
					default: out_stall = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Ends the run when nothing at all is accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		process_index = '0;
		resource_index = '0;
		amount = '0;
		last_element = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (alloc_tbl[i])
			alloc_tbl[i] = '0;
		foreach (claim_tbl[i])
			claim_tbl[i] = '0;
		foreach (avail_vec[i])
			avail_vec[i] = '0;
		foreach (req_buf[i])
			req_buf[i] = '0;
		proc_cnt = CFG_W'(MAX_PROC);
		res_cnt = CFG_W'(MAX_RES);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// The block clears its tables after reset with items stalled; the first
		// items simply wait for acceptance.
		test_directed_cases();
		test_backpressure();
		test_random_traffic();

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rra_pkg.sv
rtl/rra_regs.sv
rtl/rra_ctrl.sv
rtl/rra_dpath.sv
rtl/resource_request_admission.sv
verif/resource_request_admission_tb.sv
